### src/srrr_pkg.sv
// Shared types and constants for the selective repeat reorder receiver.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package srrr_pkg;

   localparam int SEQ_W   = 32;
   localparam int SIZE_W  = 16;
   localparam int HANDLE_W = 16;
   localparam int BYTES_W = 25;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 96;

   localparam logic [BYTES_W-1:0] LIMIT_RESET = 25'd1048576;

   typedef enum logic [1:0] {
      KIND_DELIVER  = 2'd0,
      KIND_ACK      = 2'd1,
      KIND_FINACK   = 2'd2,
      KIND_BATCHEND = 2'd3
   } kind_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic     load;        // latch the accepted packet descriptor
      logic     store;       // write the packet into its ring slot
      logic     emit;        // load the result register
      kind_type emit_kind;
      logic     emit_last;
      logic     advance;     // retire the head slot and move the window
      logic     clr_bytes;   // restart the batch byte count
      logic     set_closed;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic closed;
      logic is_fin;
      logic store_ok;
      logic head_full;
      logic over_limit;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

### src/srrr_ctrl.sv
// Controller state machine of the selective repeat reorder receiver.
// Sequences classify, store, drain and result emission; uses srrr_pkg.
`default_nettype none

module srrr_ctrl
   import srrr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_CLASS   = 6'b000010,
      S_READ    = 6'b000100,
      S_CHECK   = 6'b001000,
      S_FIN_ACK = 6'b010000,
      S_FIN_END = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.emit_kind  = KIND_ACK;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               // A closed receiver takes transfers and drops them.
               if (!status.closed) begin
                  state_in = S_CLASS;
               end
            end
         end
         S_CLASS: begin
            if (status.is_fin) begin
               state_in = S_FIN_ACK;
            end else begin
               cmd.store = status.store_ok;
               state_in  = S_READ;
            end
         end
         S_READ: begin
            // The head slot's memory word is registered into rd_ff and is valid in S_CHECK.
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               priority if (status.head_full && !status.over_limit) begin
                  cmd.emit_kind = KIND_DELIVER;
                  cmd.advance   = 1'b1;
                  state_in      = S_READ;
               end else if (status.head_full) begin
                  cmd.emit_kind = KIND_BATCHEND;
                  cmd.emit_last = 1'b1;
                  cmd.clr_bytes = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  cmd.emit_kind = KIND_ACK;
                  cmd.emit_last = 1'b1;
                  state_in      = S_IDLE;
               end
            end
         end
         S_FIN_ACK: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = KIND_FINACK;
               state_in      = S_FIN_END;
            end
         end
         S_FIN_END: begin
            if (status.out_free) begin
               cmd.emit       = 1'b1;
               cmd.emit_kind  = KIND_BATCHEND;
               cmd.emit_last  = 1'b1;
               cmd.clr_bytes  = 1'b1;
               cmd.set_closed = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### src/srrr_dp.sv
// Datapath of the selective repeat reorder receiver: window registers, slot
// flags, the slot memory, batch counter and the result register. Uses srrr_pkg.
`default_nettype none

module srrr_dp
   import srrr_pkg::*;
#(
   parameter int SLOTS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output status_type                 status,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  csr_wen,
   input  wire logic [BYTES_W-1:0]    csr_wdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic [1:0]                 rsp_tuser,
   output logic                       rsp_tlast
);

   localparam int IdxW = $clog2(SLOTS);
   localparam logic [SEQ_W-1:0] SlotsSeq = SEQ_W'(SLOTS);
   localparam logic [IdxW:0]    SlotsIdx = (IdxW + 1)'(SLOTS);
   localparam logic [IdxW-1:0]  HeadLast = IdxW'(SLOTS - 1);
   localparam int EntryW = SIZE_W + HANDLE_W;

   // Packet descriptor under classification.
   logic [SEQ_W-1:0]    seq_ff;
   logic [SIZE_W-1:0]   size_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic [SEQ_W-1:0]    diff_ff;
   logic                ge_ff;

   logic [SEQ_W-1:0]   base_ff, base_in;
   logic [IdxW-1:0]    head_ff, head_in;
   logic [BYTES_W-1:0] bytes_ff, bytes_in;
   logic [BYTES_W-1:0] limit_ff, limit_in;
   logic               closed_ff, closed_in;
   logic [SLOTS-1:0]   full_ff, full_in;

   logic [EntryW-1:0] slot_mem [SLOTS];
   logic [EntryW-1:0] rd_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0]            rsp_kind_ff, rsp_kind_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [IdxW:0]      store_sum, store_wrap;
   logic [IdxW-1:0]    store_idx;
   logic               in_window;
   logic [SIZE_W-1:0]  rd_size;
   logic [HANDLE_W-1:0] rd_handle;
   logic [BYTES_W:0]   bytes_sum;
   logic [SEQ_W-1:0]   out_number;
   logic [SIZE_W-1:0]  out_size;
   logic [HANDLE_W-1:0] out_handle;
   logic [BYTES_W-1:0] out_total;

   // Ring slot at the packet's offset from the head, wrapped once.
   assign store_sum  = {1'b0, head_ff} + {1'b0, diff_ff[IdxW-1:0]};
   assign store_wrap = store_sum - SlotsIdx;
   assign store_idx  = (store_sum >= SlotsIdx) ? store_wrap[IdxW-1:0]
                                               : store_sum[IdxW-1:0];
   assign in_window  = ge_ff && (diff_ff < SlotsSeq);

   assign rd_size   = rd_ff[EntryW-1:HANDLE_W];
   assign rd_handle = rd_ff[HANDLE_W-1:0];
   assign bytes_sum = {1'b0, bytes_ff} + (BYTES_W + 1)'(rd_size);

   always_comb begin
      status.closed     = closed_ff;
      status.is_fin     = !ge_ff && (seq_ff == '0);
      status.store_ok   = in_window && !full_ff[store_idx];
      status.head_full  = full_ff[head_ff];
      status.over_limit = bytes_sum > {1'b0, limit_ff};
      status.out_free   = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      base_in   = base_ff;
      head_in   = head_ff;
      bytes_in  = bytes_ff;
      full_in   = full_ff;
      closed_in = closed_ff || cmd.set_closed;
      limit_in  = csr_wen ? csr_wdata : limit_ff;
      if (cmd.store) begin
         full_in[store_idx] = 1'b1;
      end
      if (cmd.advance) begin
         full_in[head_ff] = 1'b0;
         base_in  = base_ff + SEQ_W'(1);
         head_in  = (head_ff == HeadLast) ? '0 : head_ff + IdxW'(1);
         bytes_in = bytes_sum[BYTES_W-1:0];
      end
      if (cmd.clr_bytes) begin
         bytes_in = '0;
      end
   end

   always_comb begin
      out_number = '0;
      out_size   = '0;
      out_handle = '0;
      out_total  = '0;
      unique case (cmd.emit_kind)
         KIND_DELIVER: begin
            out_number = base_ff;
            out_size   = rd_size;
            out_handle = rd_handle;
         end
         KIND_ACK: begin
            out_number = base_ff - SEQ_W'(1);
         end
         KIND_FINACK: begin
            out_number = '0;
         end
         KIND_BATCHEND: begin
            out_total = bytes_ff;
         end
         default: begin
            out_number = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {7'd0, out_total, out_handle, out_size, out_number};
         rsp_kind_in  = cmd.emit_kind;
         rsp_last_in  = cmd.emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= SEQ_W'(1);
         head_ff      <= '0;
         bytes_ff     <= '0;
         limit_ff     <= LIMIT_RESET;
         closed_ff    <= 1'b0;
         full_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         head_ff      <= head_in;
         bytes_ff     <= bytes_in;
         limit_ff     <= limit_in;
         closed_ff    <= closed_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         seq_ff    <= req_tdata[SEQ_W-1:0];
         size_ff   <= req_tdata[SEQ_W+SIZE_W-1:SEQ_W];
         handle_ff <= req_tdata[REQ_DATA_W-1:SEQ_W+SIZE_W];
         diff_ff   <= req_tdata[SEQ_W-1:0] - base_ff;
         ge_ff     <= req_tdata[SEQ_W-1:0] >= base_ff;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Slot memory: one write port at the store slot, one read port at the head.
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         slot_mem[store_idx] <= {size_ff, handle_ff};
      end
      rd_ff <= slot_mem[head_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

### src/selective_repeat_reorder_receiver.sv
// Top level of the selective repeat reorder receiver.
// Joins srrr_ctrl and srrr_dp; uses srrr_pkg.
//
// Each transfer on req carries one packet descriptor. A packet inside the
// receive window is stored in its ring slot; sequence number 0 below the window
// is FIN and answers with a fin ack and a batch end, after which the receiver is
// closed and drops every later transfer. Otherwise in-order stored packets are
// delivered and a cumulative ack closes the run; a delivery that would pass the
// batch byte limit gives a batch end instead and stays stored. A non-FIN item
// passes the classify, read and check states; every delivery goes back to read
// the head slot from the registered slot memory before it is checked, and a
// stalled rsp side holds the check until the result register is free. A closed
// receiver takes a transfer every cycle. The result register lets the next
// packet be accepted while the last result is still waiting.
`default_nettype none

module selective_repeat_reorder_receiver
   import srrr_pkg::*;
#(
   parameter int SLOTS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // req_tdata: seq_number[31:0], payload_size[47:32], payload_handle[63:48]
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  csr_wen,
   input  wire logic [BYTES_W-1:0]    csr_wdata,
   // rsp_tdata: number_out[31:0], size_out[47:32], handle_out[63:48],
   //            batch_total[88:64], zero fill above
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // rsp_tuser: result_kind[1:0]
   output logic [1:0]                 rsp_tuser,
   output logic                       rsp_tlast
);

   cmd_type    ctrl_cmd;
   status_type dp_status;

   srrr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (dp_status),
      .cmd        (ctrl_cmd)
   );

   srrr_dp #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (ctrl_cmd),
      .status     (dp_status),
      .req_tdata  (req_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // A result never overwrites one that is still waiting.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.emit |-> dp_status.out_free)
      else $error("result emitted while the result register is occupied");

   // Once closed, the receiver produces no further results.
   a_closed_quiet: assert property (@(posedge clock) disable iff (reset)
      dp_status.closed |-> !ctrl_cmd.emit)
      else $error("result emitted after FIN closed the receiver");

   // The window moves only together with a delivery.
   a_advance_deliver: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.advance |-> ctrl_cmd.emit && (ctrl_cmd.emit_kind == KIND_DELIVER))
      else $error("window advanced without a delivery");

endmodule

`default_nettype wire
